FILE: sv/mrtu_pkg.sv
// shared constants, types and crc helper for the modbus rtu link block
package mrtu_pkg;

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_LSB    = 16'h0001;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  localparam logic MODE_REQUEST  = 1'b0;
  localparam logic MODE_RX_BYTE  = 1'b1;
  localparam logic KIND_TX_BYTE  = 1'b0;
  localparam logic KIND_VERDICT  = 1'b1;

  // status of the request serializer toward the output stage
  typedef struct packed {
    logic       busy;
    logic [7:0] tx_byte;
    logic       frame_end;
  } tx_status_t;

  // fold one byte into a reflected crc-16 (poly 0xa001)
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/mrtu_req_framer.sv
// request frame serializer: one byte per advance, crc folded on the way out
module mrtu_req_framer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  advance,
  input  logic [7:0]            slave_address,
  input  logic [7:0]            function_code,
  input  logic [15:0]           start_register,
  input  logic [15:0]           quantity,
  output mrtu_pkg::tx_status_t  status
);
  import mrtu_pkg::*;

  logic        busy;
  logic [2:0]  idx;
  logic [7:0]  addr_q;
  logic [7:0]  func_q;
  logic [15:0] start_q;
  logic [15:0] qty_q;
  logic [15:0] crc;
  logic [7:0]  cur_byte;

  // byte at the current position
  always_comb begin
    unique case (idx)
      3'd0:    cur_byte = addr_q;
      3'd1:    cur_byte = func_q;
      3'd2:    cur_byte = start_q[15:8];
      3'd3:    cur_byte = start_q[7:0];
      3'd4:    cur_byte = qty_q[15:8];
      3'd5:    cur_byte = qty_q[7:0];
      3'd6:    cur_byte = crc[7:0];
      default: cur_byte = crc[15:8];
    endcase
  end

  assign status.busy      = busy;
  assign status.tx_byte   = cur_byte;
  assign status.frame_end = (idx == 3'd7);

  // control: busy flag and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (advance && busy) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  // frame fields and running crc
  always_ff @(posedge clk) begin
    if (load) begin
      addr_q  <= slave_address;
      func_q  <= function_code;
      start_q <= start_register;
      qty_q   <= quantity;
      crc     <= CRC_PRESET;
    end else if (advance && busy && (idx < 3'd6)) begin
      crc <= crc_fold(crc, cur_byte);
    end
  end

endmodule

FILE: sv/mrtu_rsp_checker.sv
// streaming response crc checker: holds the two newest bytes back
module mrtu_rsp_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       strobe,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  output logic       good
);
  import mrtu_pkg::*;

  logic [15:0] running_crc;
  logic [15:0] held_bytes;
  logic [1:0]  byte_count;
  logic [15:0] crc_next;
  logic [15:0] held_next;
  logic [1:0]  count_next;

  // state after taking this word
  always_comb begin
    crc_next   = (byte_count >= 2'd2) ? crc_fold(running_crc, held_bytes[15:8])
                                      : running_crc;
    held_next  = {held_bytes[7:0], rx_byte};
    count_next = (byte_count == 2'd3) ? byte_count : byte_count + 2'd1;
    good       = (count_next == 2'd3) && (crc_next == {held_next[7:0], held_next[15:8]});
  end

  // receive state, cleared after the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_PRESET;
      held_bytes  <= 16'h0000;
      byte_count  <= 2'd0;
    end else if (strobe) begin
      if (rx_last) begin
        running_crc <= CRC_PRESET;
        held_bytes  <= 16'h0000;
        byte_count  <= 2'd0;
      end else begin
        running_crc <= crc_next;
        held_bytes  <= held_next;
        byte_count  <= count_next;
      end
    end
  end

endmodule

FILE: sv/modbus_rtu_request_framer_checker.sv
// top level: modbus rtu request framer and response crc checker
// received bytes 1 per cycle; a last byte waits for an idle serializer and a free output;
// a verdict is registered when its last byte is taken; a request loads the serializer, which
// feeds its bytes to the output register; the next request is taken with the eighth byte
// reset: rst synchronous active high, empties the output and the serializer and presets the
// receive crc to 0xffff
module modbus_rtu_request_framer_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // slave_address[7:0], function_code[15:8], start_register[31:16], quantity[47:32],
  // received_byte[55:48]
  input  logic [mrtu_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode
  input  logic                              s_tuser,
  // received_last
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tx_byte[7:0], crc_good[8], zero fill[15:9]
  output logic [mrtu_pkg::OUT_DATA_W-1:0]   m_tdata,
  // kind
  output logic                              m_tuser,
  // frame_end
  output logic                              m_tlast
);
  import mrtu_pkg::*;

  tx_status_t tx_status;
  logic       out_free;
  logic       ser_emit;
  logic       ser_done;
  logic       accept;
  logic       req_load;
  logic       rx_strobe;
  logic       rx_good;

  // handshake decisions
  always_comb begin
    out_free = !m_tvalid || m_tready;
    ser_emit = tx_status.busy && out_free;
    ser_done = ser_emit && tx_status.frame_end;
    priority if (s_tuser == MODE_REQUEST) begin
      s_tready = !tx_status.busy || ser_done;
    end else if (s_tlast) begin
      s_tready = !tx_status.busy && out_free;
    end else begin
      s_tready = 1'b1;
    end
    accept    = s_tvalid && s_tready;
    req_load  = accept && (s_tuser == MODE_REQUEST);
    rx_strobe = accept && (s_tuser == MODE_RX_BYTE);
  end

  mrtu_req_framer u_framer (
    .clk            (clk),
    .rst            (rst),
    .load           (req_load),
    .advance        (ser_emit),
    .slave_address  (s_tdata[7:0]),
    .function_code  (s_tdata[15:8]),
    .start_register (s_tdata[31:16]),
    .quantity       (s_tdata[47:32]),
    .status         (tx_status)
  );

  mrtu_rsp_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .strobe  (rx_strobe),
    .rx_byte (s_tdata[55:48]),
    .rx_last (s_tlast),
    .good    (rx_good)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ser_emit || (rx_strobe && s_tlast)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (ser_emit) begin
      m_tdata <= {{(OUT_DATA_W-9){1'b0}}, 1'b0, tx_status.tx_byte};
      m_tuser <= KIND_TX_BYTE;
      m_tlast <= tx_status.frame_end;
    end else if (rx_strobe && s_tlast) begin
      m_tdata <= {{(OUT_DATA_W-9){1'b0}}, rx_good, 8'h00};
      m_tuser <= KIND_VERDICT;
      m_tlast <= 1'b1;
    end
  end

endmodule

FILE: tb/tb_top.sv
// self-checking bench for the modbus rtu request framer and response crc checker
module tb_top;
  import mrtu_pkg::*;

  // one input word as seen by the block
  typedef struct {
    logic        mode;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_register;
    logic [15:0] quantity;
    logic [7:0]  received_byte;
    logic        received_last;
    bit          wait_drain;
  } link_item_t;

  // one output word
  typedef struct {
    logic       kind;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       crc_good;
  } link_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  link_item_t stim_q[$];
  link_word_t expected_words[$];
  logic [7:0] frame_bytes[$];

  link_item_t cur_word;
  link_word_t got_word;
  link_word_t want_word;
  bit         took = 1'b0;
  int         errors = 0;
  int         send_gap = 0;
  bit         send_calm = 1'b0;
  int         send_phase = 0;
  int         stall_left = 0;
  bit         recv_calm = 1'b0;
  int         recv_phase = 0;

  // receive side shadow state
  logic [15:0] rx_crc = CRC_PRESET;
  logic [15:0] rx_hold = 16'h0000;
  logic [1:0]  rx_count = 2'd0;

  modbus_rtu_request_framer_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // bit-serial crc-16/modbus update, lsb of the data first
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                     input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ data[i]) begin
        r = {1'b0, r[15:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  // field values biased toward the extremes
  function automatic logic [15:0] pick_value(input int width);
    int r;
    logic [15:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      v = 16'h0000;
    end else if (r == 1) begin
      v = 16'hFFFF;
    end else begin
      v = 16'($urandom);
    end
    if (width == 8) begin
      v[15:8] = 8'h00;
    end
    return v;
  endfunction

  // pause after a sent word: mostly none or short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 30);
    end
  endfunction

  // expected output words for one accepted input word
  task automatic predict_link_words(input link_item_t it);
    logic [7:0]  fb [0:7];
    logic [15:0] c;
    logic [15:0] want;
    link_word_t  w;
    if (it.mode == MODE_REQUEST) begin
      fb[0] = it.slave_address;
      fb[1] = it.function_code;
      fb[2] = it.start_register[15:8];
      fb[3] = it.start_register[7:0];
      fb[4] = it.quantity[15:8];
      fb[5] = it.quantity[7:0];
      c = CRC_PRESET;
      for (int i = 0; i < 6; i++) begin
        c = crc16_modbus_step(c, fb[i]);
      end
      fb[6] = c[7:0];
      fb[7] = c[15:8];
      for (int i = 0; i < 8; i++) begin
        w.kind = KIND_TX_BYTE;
        w.tx_byte = fb[i];
        w.frame_end = (i == 7);
        w.crc_good = 1'b0;
        expected_words.push_back(w);
      end
    end else begin
      // two newest bytes are held back, older ones go into the crc
      if (rx_count >= 2) begin
        rx_crc = crc16_modbus_step(rx_crc, rx_hold[15:8]);
      end
      rx_hold = {rx_hold[7:0], it.received_byte};
      if (rx_count != 2'd3) begin
        rx_count = rx_count + 2'd1;
      end
      if (it.received_last) begin
        want = {rx_hold[7:0], rx_hold[15:8]};
        w.kind = KIND_VERDICT;
        w.tx_byte = 8'h00;
        w.frame_end = 1'b1;
        w.crc_good = (rx_count == 2'd3) && (rx_crc == want);
        expected_words.push_back(w);
        rx_crc = CRC_PRESET;
        rx_hold = 16'h0000;
        rx_count = 2'd0;
      end
    end
  endtask

  task automatic queue_request(input logic [7:0] a, input logic [7:0] f,
                               input logic [15:0] st, input logic [15:0] qty,
                               input bit drain);
    link_item_t it;
    it.mode = MODE_REQUEST;
    it.slave_address = a;
    it.function_code = f;
    it.start_register = st;
    it.quantity = qty;
    it.received_byte = 8'($urandom);
    it.received_last = 1'($urandom);
    it.wait_drain = drain;
    stim_q.push_back(it);
  endtask

  task automatic queue_random_request(input bit drain);
    queue_request(8'(pick_value(8)), 8'(pick_value(8)), pick_value(16), pick_value(16),
                  drain);
  endtask

  task automatic queue_rx_byte(input logic [7:0] b, input logic last, input bit drain);
    link_item_t it;
    it.mode = MODE_RX_BYTE;
    it.slave_address = 8'($urandom);
    it.function_code = 8'($urandom);
    it.start_register = 16'($urandom);
    it.quantity = 16'($urandom);
    it.received_byte = b;
    it.received_last = last;
    it.wait_drain = drain;
    stim_q.push_back(it);
  endtask

  // frame_bytes holds the payload; crc is appended, optionally damaged,
  // and a request may be slipped in before byte req_at
  task automatic queue_rx_frame(input bit add_crc, input bit corrupt, input int req_at,
                                input bit drain);
    logic [15:0] c;
    int pos;
    if (add_crc) begin
      c = CRC_PRESET;
      for (int i = 0; i < frame_bytes.size(); i++) begin
        c = crc16_modbus_step(c, frame_bytes[i]);
      end
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
    end
    if (corrupt) begin
      pos = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (i == req_at) begin
        queue_random_request(1'b0);
      end
      queue_rx_byte(frame_bytes[i], i == frame_bytes.size() - 1, drain && i == 0);
    end
    frame_bytes.delete();
  endtask

  // sender: one word at a time from the pending queue
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || took) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() > 0 &&
                     !(stim_q[0].wait_drain && expected_words.size() != 0)) begin
          cur_word = stim_q.pop_front();
          s_tdata <= {cur_word.received_byte, cur_word.quantity, cur_word.start_register,
                      cur_word.function_code, cur_word.slave_address};
          s_tuser <= cur_word.mode;
          s_tlast <= cur_word.received_last;
          s_tvalid <= 1'b1;
          if (send_phase == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_phase = $urandom_range(20, 80);
          end
          send_phase = send_phase - 1;
          send_gap = pick_gap(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls with calm stretches
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_phase == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
        recv_phase = $urandom_range(40, 300);
      end
      recv_phase = recv_phase - 1;
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted input words, check accepted output words
  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_link_words(cur_word);
      end
      if (m_tvalid && m_tready) begin
        got_word.kind = m_tuser;
        got_word.tx_byte = m_tdata[7:0];
        got_word.frame_end = m_tlast;
        got_word.crc_good = m_tdata[8];
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word kind %0d tx_byte %h frame_end %0d crc_good %0d",
                   $time, got_word.kind, got_word.tx_byte, got_word.frame_end,
                   got_word.crc_good);
          errors = errors + 1;
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.kind !== want_word.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want_word.kind,
                     got_word.kind);
            errors = errors + 1;
          end
          if (got_word.tx_byte !== want_word.tx_byte) begin
            $display("%0t: tx_byte expected %h actual %h", $time, want_word.tx_byte,
                     got_word.tx_byte);
            errors = errors + 1;
          end
          if (got_word.frame_end !== want_word.frame_end) begin
            $display("%0t: frame_end expected %0d actual %0d", $time, want_word.frame_end,
                     got_word.frame_end);
            errors = errors + 1;
          end
          if (got_word.crc_good !== want_word.crc_good) begin
            $display("%0t: crc_good expected %0d actual %0d", $time, want_word.crc_good,
                     got_word.crc_good);
            errors = errors + 1;
          end
          if (m_tdata[15:9] !== 7'h00) begin
            $display("%0t: tdata fill expected 00 actual %h", $time, m_tdata[15:9]);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int r;
    int n;
    // directed: request extremes and a known frame
    queue_request(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    queue_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_request(8'h01, 8'h03, 16'h0000, 16'h000A, 1'b0);
    // one-byte and two-byte frames are always bad, even with a matching crc
    queue_rx_byte(8'h55, 1'b1, 1'b0);
    queue_rx_byte(8'hFF, 1'b0, 1'b0);
    queue_rx_byte(8'hFF, 1'b1, 1'b0);
    // shortest good frame
    frame_bytes.push_back(8'hA5);
    queue_rx_frame(1'b1, 1'b0, -1, 1'b0);
    // good frame with a request in the middle, receive state must survive it
    frame_bytes = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A};
    queue_rx_frame(1'b1, 1'b0, 4, 1'b0);
    // damaged frame sent only after all output has drained
    frame_bytes = '{8'h11, 8'h22};
    queue_rx_frame(1'b1, 1'b1, -1, 1'b1);

    // random: requests, mostly well-formed frames, some noise and short or long ones
    while (stim_q.size() < 275) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        queue_random_request($urandom_range(0, 29) == 0);
      end else if (r < 30) begin
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
          queue_rx_byte(8'($urandom), i == n - 1, 1'b0);
        end
      end else if (r < 34) begin
        n = $urandom_range(20, 60);
        for (int i = 0; i < n; i++) begin
          frame_bytes.push_back(8'($urandom));
        end
        queue_rx_frame(1'b1, $urandom_range(0, 2) == 0, -1, 1'b0);
      end else if (r < 42) begin
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
          frame_bytes.push_back(8'($urandom));
        end
        queue_rx_frame(1'b0, 1'b0, -1, 1'b0);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          frame_bytes.push_back(8'(pick_value(8)));
        end
        queue_rx_frame(1'b1, $urandom_range(0, 99) < 15,
                       ($urandom_range(0, 99) < 12) ? $urandom_range(1, n + 1) : -1,
                       $urandom_range(0, 29) == 0);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || s_tvalid) begin
      @(posedge clk);
    end
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("modbus_rtu_request_framer_checker verification clean");
    end else begin
      $display("modbus_rtu_request_framer_checker verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("modbus_rtu_request_framer_checker verification failed");
    $finish;
  end

endmodule
